FILE: rtl/core/bounded_deque_with_indexed_read_macros.svh
// assertion macros for the bounded deque
`ifndef BOUNDED_DEQUE_WITH_INDEXED_READ_MACROS_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_READ_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bdq_pkg.sv
// types and constants of the bounded deque
package bdq_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InW     = 40;
  localparam int unsigned OutW    = 40;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ_INDEX = 3'd4,
    CMD_READ_FRONT = 3'd5,
    CMD_READ_BACK  = 3'd6
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

FILE: rtl/core/bdq_ram.sv
// single-port synchronous ram with registered read
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bounded_deque_with_indexed_read.sv
// bounded double-ended queue held as a ring in one ram, with indexed read
//
//  channel  dir  fields (tdata from bit 0 up)
//  s_axis   in   command[2:0], value[34:3], position[38:35], zero pad[39]
//  m_axis   out  data[31:0], count[36:32], is_empty[37], status[39:38]
//
// one command per cycle while results are taken; each result passes through the
// registered ram read and then the output register
// head and count sit in flops and update at acceptance, so the next command sees them
// a held result stalls the ram stage, which then stops input; ram data waits there
// reset clears head, count and both stage valids; ram contents stay undefined
module bounded_deque_with_indexed_read #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [bdq_pkg::InW-1:0]   s_axis_tdata,  // command, value, position
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bdq_pkg::OutW-1:0]  m_axis_tdata   // data, count, is_empty, status
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned CmpW = (CntW > bdq_pkg::PosW) ? CntW : bdq_pkg::PosW;
  localparam int unsigned ExtW = (DATA_WIDTH > bdq_pkg::DataW) ? DATA_WIDTH : bdq_pkg::DataW;
  localparam int unsigned CoW  = (CntW > bdq_pkg::CountW) ? CntW : bdq_pkg::CountW;

  function automatic logic [PtrW-1:0] wrap_add(logic [PtrW-1:0] base, logic [CntW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(DEPTH)) begin
      sum = sum - SumW'(DEPTH);
    end
    return sum[PtrW-1:0];
  endfunction

  // state
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  // ram stage
  logic                 s1_valid_q;
  logic                 s1_rd_q;
  logic [CntW-1:0]      s1_count_q;
  bdq_pkg::status_e     s1_status_q;

  // output register
  logic                    out_valid_q;
  logic [bdq_pkg::DataW-1:0]  out_data_q;
  logic [bdq_pkg::CountW-1:0] out_count_q;
  logic                    out_empty_q;
  bdq_pkg::status_e        out_status_q;

  bdq_pkg::cmd_e            cmd;
  logic [bdq_pkg::ValueW-1:0] val;
  logic [bdq_pkg::PosW-1:0] pos;
  logic [CmpW-1:0]          pos_ext;
  logic [CmpW-1:0]          cnt_ext;
  logic [ExtW-1:0]          val_ext;
  logic [ExtW-1:0]          rd_ext;
  logic [CoW-1:0]           cnt_out_ext;

  logic                   s_fire, s1_adv;
  logic                   is_empty, is_full;
  logic                   mem_en, mem_we, rd_flag;
  logic [PtrW-1:0]        mem_addr;
  logic [DATA_WIDTH-1:0]  mem_wdata, mem_rdata;
  bdq_pkg::status_e       status;

  assign cmd     = bdq_pkg::cmd_e'(s_axis_tdata[2:0]);
  assign val     = s_axis_tdata[34:3];
  assign pos     = s_axis_tdata[38:35];
  assign pos_ext = CmpW'(pos);
  assign cnt_ext = CmpW'(count_q);
  assign val_ext = ExtW'(val);
  assign mem_wdata = val_ext[DATA_WIDTH-1:0];

  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(DEPTH));

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = head_q;
    rd_flag  = 1'b0;
    status   = bdq_pkg::ST_OK;
    unique case (cmd)
      bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status = bdq_pkg::ST_FULL;
        end else begin
          mem_en  = 1'b1;
          mem_we  = 1'b1;
          count_d = count_q + CntW'(1);
          if (cmd == bdq_pkg::CMD_PUSH_FRONT) begin
            head_d   = (head_q == '0) ? PtrW'(DEPTH - 1) : head_q - PtrW'(1);
            mem_addr = head_d;
          end else begin
            mem_addr = wrap_add(head_q, count_q);
          end
        end
      end
      bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_READ_FRONT: begin
        if (is_empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          mem_en   = 1'b1;
          rd_flag  = 1'b1;
          mem_addr = head_q;
          if (cmd == bdq_pkg::CMD_POP_FRONT) begin
            head_d  = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + PtrW'(1);
            count_d = count_q - CntW'(1);
          end
        end
      end
      bdq_pkg::CMD_POP_BACK, bdq_pkg::CMD_READ_BACK: begin
        if (is_empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else begin
          mem_en   = 1'b1;
          rd_flag  = 1'b1;
          mem_addr = wrap_add(head_q, count_q - CntW'(1));
          if (cmd == bdq_pkg::CMD_POP_BACK) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      bdq_pkg::CMD_READ_INDEX: begin
        if (is_empty) begin
          status = bdq_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status = bdq_pkg::ST_RANGE;
        end else begin
          mem_en   = 1'b1;
          rd_flag  = 1'b1;
          mem_addr = wrap_add(head_q, pos_ext[CntW-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (s_fire && mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        head_q     <= head_d;
        count_q    <= count_d;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rd_ext      = ExtW'(mem_rdata);
  assign cnt_out_ext = CoW'(s1_count_q);

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_rd_q     <= rd_flag;
      s1_count_q  <= count_d;
      s1_status_q <= status;
    end
    if (s1_valid_q && s1_adv) begin
      out_data_q   <= s1_rd_q ? rd_ext[bdq_pkg::DataW-1:0] : '0;
      out_count_q  <= cnt_out_ext[bdq_pkg::CountW-1:0];
      out_empty_q  <= (s1_count_q == '0);
      out_status_q <= s1_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_status_q, out_empty_q, out_count_q, out_data_q};

  `include "bounded_deque_with_indexed_read_macros.svh"

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(DEPTH), "count above capacity")
  `BDQ_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_count_q), "ram stage lost while stalled")
  `BDQ_ASSERT_NEXT(a_full_push, s_fire && is_full && (cmd == bdq_pkg::CMD_PUSH_FRONT || cmd == bdq_pkg::CMD_PUSH_BACK), s1_status_q == bdq_pkg::ST_FULL && $stable(count_q), "push on full changed state")

endmodule
